// File: rtl/rcld_pkg.sv
// ---------------------------------------------------------------------------
// rcld_pkg
// Shared types and constants for the rtsp credential leak detector.
// ---------------------------------------------------------------------------
package rcld_pkg;

	// Byte classes produced by the front end
	typedef enum logic [3:0] {
		CLS_OTHER = 4'd0,
		CLS_R     = 4'd1,
		CLS_T     = 4'd2,
		CLS_S     = 4'd3,
		CLS_P     = 4'd4,
		CLS_COLON = 4'd5,
		CLS_SLASH = 4'd6,
		CLS_AT    = 4'd7,
		CLS_STAR  = 4'd8,
		CLS_TERM  = 4'd9
	} cls_t;

	// One classified beat handed from front to back
	typedef struct packed {
		cls_t cls;
		logic fin;
	} item_t;

	localparam logic [2:0] SCHEME_LAST = 3'd6;

	// Class expected at each position of "rtsp://"
	function automatic cls_t scheme_cls(input logic [2:0] idx);
		cls_t c;
		unique case (idx)
			3'd0: c = CLS_R;
			3'd1: c = CLS_T;
			3'd2: c = CLS_S;
			3'd3: c = CLS_P;
			3'd4: c = CLS_COLON;
			default: c = CLS_SLASH;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/rcld_front.sv
// ---------------------------------------------------------------------------
// rcld_front
// Accepts text bytes and classifies each into a small class code.
// ---------------------------------------------------------------------------
module rcld_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_take,
	input  logic [7:0]           text_byte,
	input  logic                 final_byte,
	input  logic                 q_full,
	output logic                 stall,
	output logic                 q_push,
	output rcld_pkg::item_t      q_item
);
	import rcld_pkg::*;

	logic  vld_s1;
	item_t item_s1;
	cls_t  cls;

	always_comb begin
		unique case (text_byte)
			8'h72, 8'h52: cls = CLS_R;
			8'h74, 8'h54: cls = CLS_T;
			8'h73, 8'h53: cls = CLS_S;
			8'h70, 8'h50: cls = CLS_P;
			8'h3A:        cls = CLS_COLON;
			8'h2F:        cls = CLS_SLASH;
			8'h40:        cls = CLS_AT;
			8'h2A:        cls = CLS_STAR;
			8'h3F, 8'h23, 8'h22, 8'h27, 8'h20,
			8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: cls = CLS_TERM;
			default:      cls = CLS_OTHER;
		endcase
	end

	// Hold the stage while the queue is full
	assign stall  = vld_s1 && q_full;
	assign q_push = vld_s1 && !q_full;
	assign q_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!stall) begin
			vld_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.cls <= cls;
			item_s1.fin <= final_byte;
		end
	end

endmodule

// File: rtl/rcld_fifo.sv
// ---------------------------------------------------------------------------
// rcld_fifo
// Short queue of classified beats between front and back.
// ---------------------------------------------------------------------------
module rcld_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rcld_pkg::item_t push_item,
	input  logic            pop,
	output rcld_pkg::item_t head,
	output logic            full,
	output logic            empty
);
	import rcld_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	item_t         mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: rtl/rcld_back.sv
// ---------------------------------------------------------------------------
// rcld_back
// Runs the scheme match and authority tracking; holds the result beat.
// ---------------------------------------------------------------------------
module rcld_back (
	input  logic            clk,
	input  logic            arst_n,
	input  rcld_pkg::item_t q_head,
	input  logic            q_empty,
	output logic            q_pop,
	input  logic            pop,
	output logic            empty,
	output logic            has_exposed_password
);
	import rcld_pkg::*;

	logic [2:0] match_q;
	logic       in_auth_q;
	logic       past_at_q;
	logic       colon_q;
	logic [1:0] star_q;
	logic       mask_q;
	logic       leak_q;
	logic       res_vld_q;
	logic       res_q;

	logic [2:0] match_d;
	logic       in_auth_d;
	logic       past_at_d;
	logic       colon_d;
	logic [1:0] star_d;
	logic       mask_d;
	logic       leak_d;
	logic       take;
	cls_t       c;

	assign c     = q_head.cls;
	// only a final beat needs the result register free
	assign take  = !q_empty && (!res_vld_q || pop || !q_head.fin);
	assign q_pop = take;
	assign empty = !res_vld_q;
	assign has_exposed_password = res_q;

	always_comb begin
		match_d   = match_q;
		in_auth_d = in_auth_q;
		past_at_d = past_at_q;
		colon_d   = colon_q;
		star_d    = star_q;
		mask_d    = mask_q;
		leak_d    = leak_q;
		if (!in_auth_q || c == CLS_SLASH || c == CLS_TERM) begin
			in_auth_d = 1'b0;
			if (c == scheme_cls(match_q)) begin
				if (match_q == SCHEME_LAST) begin
					match_d   = '0;
					in_auth_d = 1'b1;
					past_at_d = 1'b0;
					colon_d   = 1'b0;
					star_d    = '0;
					mask_d    = 1'b0;
				end else begin
					match_d = match_q + 3'd1;
				end
			end else begin
				match_d = (c == CLS_R) ? 3'd1 : 3'd0;
			end
		end else if (!past_at_q) begin
			if (c == CLS_AT) begin
				past_at_d = 1'b1;
				leak_d    = leak_q || (colon_q && !mask_q);
			end else begin
				if (c == CLS_COLON) begin
					colon_d = 1'b1;
				end
				if (c == CLS_STAR) begin
					if (star_q == 2'd2) begin
						mask_d = 1'b1;
					end else begin
						star_d = star_q + 2'd1;
					end
				end else begin
					star_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q   <= '0;
			in_auth_q <= 1'b0;
			past_at_q <= 1'b0;
			colon_q   <= 1'b0;
			star_q    <= '0;
			mask_q    <= 1'b0;
			leak_q    <= 1'b0;
			res_vld_q <= 1'b0;
			res_q     <= 1'b0;
		end else begin
			if (take && q_head.fin) begin
				res_vld_q <= 1'b1;
			end else if (pop && res_vld_q) begin
				res_vld_q <= 1'b0;
			end
			if (take) begin
				if (q_head.fin) begin
					// emit the verdict and clear for the next text
					res_q     <= leak_d;
					match_q   <= '0;
					in_auth_q <= 1'b0;
					past_at_q <= 1'b0;
					colon_q   <= 1'b0;
					star_q    <= '0;
					mask_q    <= 1'b0;
					leak_q    <= 1'b0;
				end else begin
					match_q   <= match_d;
					in_auth_q <= in_auth_d;
					past_at_q <= past_at_d;
					colon_q   <= colon_d;
					star_q    <= star_d;
					mask_q    <= mask_d;
					leak_q    <= leak_d;
				end
			end
		end
	end

endmodule

// File: rtl/rtsp_credential_leak_detector_unit.sv
// ---------------------------------------------------------------------------
// rtsp_credential_leak_detector_unit
// Flags text that carries an rtsp:// URI with an unmasked user:password.
// ---------------------------------------------------------------------------
// Push one text byte per beat, with final_byte set on the last byte of a text.
// While full is low the block sustains one byte per clock: a front stage
// classifies each byte, a queue of DEPTH beats decouples it from the back
// end, and the back end advances the match state by one byte per clock
// while beats are queued and no last byte waits. One verdict beat per text
// appears on the result side, through the front stage, queue and result
// register. Bytes of the next text keep flowing while the verdict waits to
// be popped; only the next last byte waits in the back end, and input
// stalls once the queue behind it fills.
module rtsp_credential_leak_detector_unit #(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] text_byte,
	input  logic       final_byte,
	output logic       empty,
	input  logic       pop,
	output logic       has_exposed_password
);
	import rcld_pkg::*;

	logic  in_take;
	logic  q_push;
	logic  q_full;
	logic  q_empty;
	logic  q_pop;
	item_t q_item;
	item_t q_head;

	assign in_take = push && !full;

	rcld_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_take    (in_take),
		.text_byte  (text_byte),
		.final_byte (final_byte),
		.q_full     (q_full),
		.stall      (full),
		.q_push     (q_push),
		.q_item     (q_item)
	);

	rcld_fifo #(
		.DEPTH (DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	rcld_back u_back (
		.clk                  (clk),
		.arst_n               (arst_n),
		.q_head               (q_head),
		.q_empty              (q_empty),
		.q_pop                (q_pop),
		.pop                  (pop),
		.empty                (empty),
		.has_exposed_password (has_exposed_password)
	);

	a_take_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("back end took a beat from an empty queue");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> q_push || full)
		else $error("accepted byte missing from front stage");

	a_final_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_head.fin) |=> !empty)
		else $error("final beat produced no verdict");

	a_full_means_queue_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> q_full)
		else $error("input stalled with room in the queue");

endmodule
